// ===== src/mrt_pkg.sv =====
package mrt_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 9;
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 3;
    localparam int WEIGHT_W = 17;

    // Q1.16 value of 1.5
    localparam int WEIGHT_MAX = 98304;

    localparam logic [FUNC_W-1:0] FUNC_TXT_BIAS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_IMG_BIAS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SCORE    = 2'd2;

endpackage

// ===== src/mrt_in_if.sv =====
interface mrt_in_if
    import mrt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     expert_index;
    logic signed [VALUE_W-1:0] value;
    logic                img_sel;
    logic                last_element;

    modport source (output valid, func, expert_index, value, img_sel, last_element,
                    input ready);
    modport sink   (input valid, func, expert_index, value, img_sel, last_element,
                    output ready);
endinterface

// ===== src/mrt_out_if.sv =====
interface mrt_out_if
    import mrt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [RANK_W-1:0]   rank;
    logic [ID_W-1:0]     expert_id;
    logic [WEIGHT_W-1:0] weight;
    logic                last_of_run;

    modport source (output valid, rank, expert_id, weight, last_of_run, input ready);
    modport sink   (input valid, rank, expert_id, weight, last_of_run, output ready);
endinterface

// ===== src/moe_router_top6_select.sv =====
// Mixture-of-experts top-k router.
// Input channel i_in carries bias writes (text or image table) and expert
// scores; output channel o_out carries TOP_K ranked results per token.
// A bias write leaves the sequencer idle. A score goes through the bias table
// read and key add (S_READ), then compares kept entries one at a time
// (1 to TOP_K of them) in the single key comparator. On a score with
// last_element set the block then sums the kept scores entry by entry and,
// for each rank, takes a set-up step, runs the shared restoring divider (one
// quotient bit a cycle, then the clamp) and holds the result on o_out until
// taken. An empty rank, a zero sum or a score of the other sign than the sum
// skips the divider.
// i_in.ready is high only while the sequencer is idle; one transaction is
// in flight at a time. A stall on o_out holds the current result and the
// sequencer. Reset clears the sequencer and the kept list; the bias tables
// are not cleared and must be written before they are used.
module moe_router_top6_select
    import mrt_pkg::*;
#(
    parameter int NUM_EXPERTS = 384,
    parameter int TOP_K       = 6,
    parameter int SCORE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrt_in_if.sink    i_in,
    mrt_out_if.source o_out
);
    localparam int AW  = $clog2(NUM_EXPERTS);
    localparam int KW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int SW  = SCORE_WIDTH + 3;
    localparam int NW  = SCORE_WIDTH + 17;
    localparam int CW  = $clog2(NW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_FIND, S_SUM, S_DIVSET, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic signed [SCORE_WIDTH:0]   r_key   [TOP_K];
    logic signed [SCORE_WIDTH-1:0] r_score [TOP_K];
    logic [ID_W-1:0]               r_id    [TOP_K];
    logic [TOP_K-1:0]              r_valid;

    logic signed [SCORE_WIDTH-1:0] r_val;
    logic signed [SCORE_WIDTH:0]   r_ckey;
    logic [ID_W-1:0]               r_idx;
    logic                          r_img;
    logic                          r_last;
    logic [KW-1:0]                 r_pos;
    logic signed [SW-1:0]          r_sum;
    logic [SW:0]                   r_rem;
    logic [NW-1:0]                 r_quo;
    logic [SW-1:0]                 r_den;
    logic [CW-1:0]                 r_cnt;
    logic [WEIGHT_W-1:0]           r_weight;

    logic                          accept;
    logic                          idx_ok;
    logic signed [SCORE_WIDTH-1:0] in_val;
    logic [SCORE_WIDTH-1:0]        text_rd;
    logic [SCORE_WIDTH-1:0]        image_rd;
    logic                          ahead;
    logic                          last_pos;
    logic signed [SCORE_WIDTH-1:0] cur_score;
    logic [SCORE_WIDTH:0]          score_mag;
    logic [NW-1:0]                 num_mag;
    logic [SW-1:0]                 sum_mag;
    logic [SW:0]                   trial;
    logic                          trial_ge;

    assign accept  = i_in.valid && i_in.ready;
    assign idx_ok  = {23'b0, i_in.expert_index} < 32'(NUM_EXPERTS);
    assign in_val  = i_in.value[SCORE_WIDTH-1:0];
    assign i_in.ready = (r_state == S_IDLE);

    mrt_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(NUM_EXPERTS)) u_txt_tbl (
        .i_clk   (i_clk),
        .i_we    (accept && idx_ok && i_in.func == FUNC_TXT_BIAS),
        .i_waddr (AW'(i_in.expert_index)),
        .i_wdata (in_val),
        .i_raddr (AW'(i_in.expert_index)),
        .o_rdata (text_rd)
    );

    mrt_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(NUM_EXPERTS)) u_img_tbl (
        .i_clk   (i_clk),
        .i_we    (accept && idx_ok && i_in.func == FUNC_IMG_BIAS),
        .i_waddr (AW'(i_in.expert_index)),
        .i_wdata (in_val),
        .i_raddr (AW'(i_in.expert_index)),
        .o_rdata (image_rd)
    );

    // shared comparator: does kept entry r_pos stay ahead of the candidate
    always_comb begin
        ahead = r_valid[r_pos] &&
                ((r_key[r_pos] > r_ckey) ||
                 ((r_key[r_pos] == r_ckey) && (r_id[r_pos] <= r_idx)));
    end
    assign last_pos = (r_pos == KW'(TOP_K - 1));

    assign cur_score = r_score[r_pos];
    assign score_mag = cur_score[SCORE_WIDTH-1] ?
                       (SCORE_WIDTH + 1)'(-SW'(cur_score)) :
                       (SCORE_WIDTH + 1)'(cur_score);
    // times 1.5 in Q16: x * 2^16 + x * 2^15
    assign num_mag   = (NW'(score_mag) << 16) + (NW'(score_mag) << 15);
    assign sum_mag   = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign trial     = {r_rem[SW-1:0], r_quo[NW-1]};
    assign trial_ge  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pos   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in.func == FUNC_SCORE) begin
                        r_val  <= in_val;
                        r_idx  <= i_in.expert_index;
                        r_img  <= i_in.img_sel;
                        r_last <= i_in.last_element;
                        r_pos  <= '0;
                        r_sum  <= '0;
                        if (idx_ok) begin
                            r_state <= S_READ;
                        end else if (i_in.last_element) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_READ: begin
                    r_ckey  <= (SCORE_WIDTH + 1)'(r_val) + (SCORE_WIDTH + 1)'(
                               $signed(r_img ? image_rd : text_rd));
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    if (!ahead) begin
                        for (int i = TOP_K - 1; i > 0; i--) begin
                            if (KW'(i) > r_pos) begin
                                r_key[i]   <= r_key[i-1];
                                r_score[i] <= r_score[i-1];
                                r_id[i]    <= r_id[i-1];
                                r_valid[i] <= r_valid[i-1];
                            end
                        end
                        r_key[r_pos]   <= r_ckey;
                        r_score[r_pos] <= r_val;
                        r_id[r_pos]    <= r_idx;
                        r_valid[r_pos] <= 1'b1;
                    end
                    if (!ahead || last_pos) begin
                        r_pos   <= '0;
                        r_state <= r_last ? S_SUM : S_IDLE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_SUM: begin
                    if (r_valid[r_pos]) begin
                        r_sum <= r_sum + SW'(cur_score);
                    end
                    if (last_pos) begin
                        r_pos   <= '0;
                        r_state <= S_DIVSET;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_DIVSET: begin
                    // drop empty ranks, zero sum and a negative quotient
                    if (!r_valid[r_pos] || r_sum == '0 ||
                        cur_score[SCORE_WIDTH-1] != r_sum[SW-1]) begin
                        r_weight <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= num_mag;
                        r_den   <= sum_mag;
                        r_cnt   <= CW'(NW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_weight <= (r_quo > NW'(WEIGHT_MAX)) ?
                                    WEIGHT_W'(WEIGHT_MAX) : WEIGHT_W'(r_quo);
                        r_state  <= S_OUT;
                    end else begin
                        r_rem <= trial_ge ? (trial - {1'b0, r_den}) : trial;
                        r_quo <= {r_quo[NW-2:0], trial_ge};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        if (last_pos) begin
                            r_valid <= '0;
                            r_pos   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_DIVSET;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.rank        = RANK_W'(r_pos);
    assign o_out.expert_id   = r_valid[r_pos] ? r_id[r_pos] : '0;
    assign o_out.weight      = r_weight;
    assign o_out.last_of_run = last_pos;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input taken while a result is pending");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, r_valid} + (TOP_K + 1)'(1)))
        else $error("kept list has a gap");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.weight <= WEIGHT_W'(WEIGHT_MAX))
        else $error("weight above 1.5");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run) |=> r_valid == '0)
        else $error("kept list not cleared after token");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= KW'(TOP_K - 1))
        else $error("rank pointer out of range");
endmodule

// ===== src/mrt_ram.sv =====
module mrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== bench/moe_router_top6_select_tb.sv =====
`timescale 1ns / 100ps

module moe_router_top6_select_tb;
    import mrt_pkg::*;

    localparam int NEXP      = 384;
    localparam int KEEP      = 6;
    localparam int MAX_CYC   = 3000000;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [ID_W-1:0]     expert_id;
        logic [WEIGHT_W-1:0] weight;
        logic                last_of_run;
    } route_t;

    logic i_clk;
    logic i_rst_n;

    mrt_in_if  in_ch ();
    mrt_out_if out_ch ();

    moe_router_top6_select dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state
    logic signed [31:0] bias_txt [NEXP];
    logic signed [31:0] bias_img [NEXP];
    bit                 text_set [NEXP];
    bit                 image_set [NEXP];
    logic signed [32:0] kept_key [KEEP];
    logic signed [31:0] kept_score [KEEP];
    logic [ID_W-1:0]    kept_id [KEEP];
    bit                 kept_ok [KEEP];

    route_t routes_due [$];
    int     errors;
    int     cycles;
    int     tokens_done;
    int     results_seen;
    bit     calm;
    bit     hold_rx;

    task automatic clear_kept();
        for (int i = 0; i < KEEP; i++) begin
            kept_key[i]   = -(33'sd1 <<< 32);
            kept_score[i] = '0;
            kept_id[i]    = '0;
            kept_ok[i]    = 1'b0;
        end
    endtask

    task automatic rank_candidate(logic signed [32:0] key, logic signed [31:0] sc,
                                  logic [ID_W-1:0] id);
        int p;
        p = 0;
        while (p < KEEP && kept_ok[p] &&
               (kept_key[p] > key || (kept_key[p] == key && kept_id[p] <= id)))
            p++;
        if (p < KEEP) begin
            for (int i = KEEP - 1; i > p; i--) begin
                kept_key[i]   = kept_key[i-1];
                kept_score[i] = kept_score[i-1];
                kept_id[i]    = kept_id[i-1];
                kept_ok[i]    = kept_ok[i-1];
            end
            kept_key[p]   = key;
            kept_score[p] = sc;
            kept_id[p]    = id;
            kept_ok[p]    = 1'b1;
        end
    endtask

    task automatic predict_routes(logic [1:0] fn, logic [ID_W-1:0] idx,
                                  logic signed [31:0] val, logic img, logic lst);
        logic signed [63:0] sum;
        logic signed [63:0] q;
        logic signed [32:0] bias;
        route_t r;
        sum = 0;
        if (fn == FUNC_TXT_BIAS || fn == FUNC_IMG_BIAS) begin
            if (idx < NEXP) begin
                if (fn == FUNC_TXT_BIAS) begin
                    bias_txt[idx] = val;
                    text_set[idx] = 1'b1;
                end else begin
                    bias_img[idx]  = val;
                    image_set[idx] = 1'b1;
                end
            end
            return;
        end
        if (fn != FUNC_SCORE) return;
        if (idx < NEXP) begin
            bias = img ? bias_img[idx] : bias_txt[idx];
            rank_candidate(33'(val) + bias, val, idx);
        end
        if (!lst) return;
        for (int k = 0; k < KEEP; k++)
            if (kept_ok[k]) sum += kept_score[k];
        for (int k = 0; k < KEEP; k++) begin
            r = '0;
            r.rank = k[RANK_W-1:0];
            r.last_of_run = (k == KEEP - 1);
            if (kept_ok[k]) begin
                r.expert_id = kept_id[k];
                if (sum != 0) begin
                    q = (64'(kept_score[k]) * WEIGHT_MAX) / sum;
                    if (q < 0) q = 0;
                    if (q > WEIGHT_MAX) q = WEIGHT_MAX;
                    r.weight = q[WEIGHT_W-1:0];
                end
            end
            routes_due.push_back(r);
        end
        tokens_done++;
        clear_kept();
    endtask

    // send one transaction and update the prediction when it is taken
    task automatic send_item(logic [1:0] fn, logic [ID_W-1:0] idx, logic [31:0] val,
                             logic img, logic lst);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= fn;
        in_ch.expert_index <= idx;
        in_ch.value        <= val;
        in_ch.img_sel      <= img;
        in_ch.last_element <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_routes(fn, idx, val, img, lst);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (routes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // picks only experts with both biases written
    function automatic logic [ID_W-1:0] pick_expert();
        logic [ID_W-1:0] e;
        do e = 9'($urandom_range(0, NEXP - 1)); while (!(text_set[e] && image_set[e]));
        return e;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("%0t timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) out_ch.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        route_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.rank, out_ch.expert_id, out_ch.weight, out_ch.last_of_run};
            results_seen++;
            if (routes_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: got %p", $time, got);
            end else begin
                want = routes_due.pop_front();
                if (got.rank != want.rank || got.expert_id != want.expert_id ||
                    got.weight != want.weight || got.last_of_run != want.last_of_run) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    // load both tables for experts 0..31 and 352..383
    task automatic test_load_bias();
        int e;
        for (int n = 0; n < 64; n++) begin
            e = (n < 32) ? n : n + 320;
            send_item(FUNC_TXT_BIAS, 9'(e), $urandom_range(0, 16) == 0 ? 32'h8000_0000 :
                      32'(int'($urandom_range(0, 131072)) - 65536), 1'b0, e[0]);
            send_item(FUNC_IMG_BIAS, 9'(e), $urandom_range(0, 16) == 0 ? 32'h7fff_ffff :
                      32'(int'($urandom_range(0, 131072)) - 65536), 1'b1, 1'b0);
        end
        // out-of-range index and func 3 are ignored
        send_item(FUNC_TXT_BIAS, 9'h1ff, 32'h1234_5678, 1'b0, 1'b1);
        send_item(FUNC_IMG_BIAS, 9'd384, 32'hdead_beef, 1'b1, 1'b0);
        send_item(2'd3, 9'd5, 32'hffff_ffff, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_directed();
        // extremes and a one-entry token
        send_item(FUNC_SCORE, 9'd0, 32'h7fff_ffff, 1'b0, 1'b0);
        send_item(FUNC_SCORE, 9'd383, 32'h8000_0000, 1'b1, 1'b1);
        send_item(FUNC_SCORE, 9'd7, 32'h0001_0000, 1'b1, 1'b1);
        // zero sum
        send_item(FUNC_SCORE, 9'd1, 32'h0001_0000, 1'b0, 1'b0);
        send_item(FUNC_SCORE, 9'd2, 32'hffff_0000, 1'b0, 1'b1);
        // repeated expert, equal keys
        for (int i = 0; i < 4; i++)
            send_item(FUNC_SCORE, 9'd10, 32'h0002_0000, 1'b0, 1'b0);
        // dropped index still closes the token
        send_item(FUNC_SCORE, 9'h1ff, 32'h0005_0000, 1'b0, 1'b1);
        // eight scores, mixed signs: negative and saturated weights
        for (int i = 0; i < 8; i++)
            send_item(FUNC_SCORE, 9'(20 + i), i[0] ? 32'hfff0_0000 : 32'h0030_0000,
                      i[1], i == 7);
        drain();
    endtask

    task automatic test_random(int n);
        int left;
        int len;
        left = n;
        while (left > 0) begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 8);
            for (int j = 0; j < len && left > 0; j++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(FUNC_TXT_BIAS, 9'($urandom_range(0, 511)), $urandom(), 1'b0,
                              1'($urandom_range(0, 1)));
                else
                    send_item(FUNC_SCORE,
                              $urandom_range(0, 30) == 0 ? 9'($urandom_range(384, 511))
                                                         : pick_expert(),
                              $urandom_range(0, 4) == 0 ? $urandom()
                                  : 32'(int'($urandom_range(0, 400000)) - 100000),
                              1'($urandom_range(0, 1)), j == len - 1);
                left--;
            end
        end
        send_item(FUNC_SCORE, pick_expert(), 32'h0000_8000, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        int hold;
        hold_rx = 1'b1;
        fork
            begin
                hold = 0;
                while (hold < 400) begin
                    @(posedge i_clk);
                    hold++;
                end
                hold_rx = 1'b0;
            end
            for (int t = 0; t < 3; t++)
                for (int j = 0; j < 6; j++)
                    send_item(FUNC_SCORE, pick_expert(), $urandom(), j[0], j == 5);
        join
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        tokens_done = 0;
        results_seen = 0;
        calm = 1'b0;
        hold_rx = 1'b0;
        for (int e = 0; e < NEXP; e++) begin
            text_set[e]  = 1'b0;
            image_set[e] = 1'b0;
            bias_txt[e]  = '0;
            bias_img[e]  = '0;
        end
        clear_kept();
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.expert_index = '0;
        in_ch.value = '0;
        in_ch.img_sel = 1'b0;
        in_ch.last_element = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_bias();
        test_directed();
        test_random(200);
        test_backpressure();
        calm = 1'b1;
        test_random(40);

        $display("covered bias loads, %0d tokens, %0d ranked results", tokens_done,
                 results_seen);
        $display("including ties, repeats, dropped indices, saturation and a long stall");
        if (errors == 0 && routes_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mrt_pkg.sv
src/mrt_in_if.sv
src/mrt_out_if.sv
src/mrt_ram.sv
src/moe_router_top6_select.sv
bench/moe_router_top6_select_tb.sv
